// ===== rtl/mtit_pkg.sv =====
// Shared types and constants for the multi-task interval timer.
package mtit_pkg;

  // Table size and the most results one tick may give.
  localparam int MAX_TASKS   = 16;
  localparam int MAX_RESULTS = 16;

  // Entry index, entry count and result count widths.
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  // Field widths of one table entry.
  localparam int ID_W   = 16;
  localparam int IVL_W  = 24;
  localparam int TIME_W = 32;
  localparam int REM_W  = 16;

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SET  = 2'd1,
    CMD_STOP = 2'd2,
    CMD_TICK = 2'd3
  } command_t;

  // Result kinds.
  localparam logic KIND_FIRED  = 1'b0;
  localparam logic KIND_REJECT = 1'b1;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // One task in the table.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [IVL_W-1:0]  interval;
    logic [TIME_W-1:0] start;
    logic [REM_W-1:0]  remaining;
  } entry_t;

  // Write port of the task table.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } tbl_wr_t;

  // One result without its last flag.
  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] id;
    logic            fin;
  } res_t;

endpackage

// ===== rtl/mtit_cmd_if.sv =====
// Request channel of the interval timer: valid, ready and the command payload.
interface mtit_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] task_id;
  logic [23:0] interval_ms;
  logic [15:0] run_limit;
  logic [31:0] now_ms;

  modport source (
    output valid, command, task_id, interval_ms, run_limit, now_ms,
    input  ready
  );
  modport sink (
    input  valid, command, task_id, interval_ms, run_limit, now_ms,
    output ready
  );
endinterface

// ===== rtl/mtit_res_if.sv =====
// Result channel of the interval timer: valid, ready and the result payload.
interface mtit_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [15:0] fired_task_id;
  logic        finished;
  logic        last;

  modport source (
    output valid, result_kind, fired_task_id, finished, last,
    input  ready
  );
  modport sink (
    input  valid, result_kind, fired_task_id, finished, last,
    output ready
  );
endinterface

// ===== rtl/mtit_table.sv =====
// Task table storage with one write port and one read port.
module mtit_table
  import mtit_pkg::*;
(
  input  logic             clk,
  input  tbl_wr_t          wr,
  input  logic [IDX_W-1:0] rd_idx,
  output entry_t           rd_data
);

  entry_t entries [MAX_TASKS];

  // Entries are only read below the fill count, so they need no reset.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      entries[wr.idx] <= wr.data;
    end
  end

  assign rd_data = entries[rd_idx];

endmodule

// ===== rtl/multi_task_interval_timer.sv =====
// Top level of the multi-task interval timer: sequencer, shared compare unit and output stage.
//
// The block keeps up to MAX_TASKS timed tasks in insertion order. An add writes the
// table from the idle state; when the table is full, it passes instead through a flush
// state that hands the rejection to the output register. Set interval, stop and tick
// pass through the accepting idle state, a scan step per entry while one shared
// elapsed-time compare unit visits the table through its single read port, a step that
// closes the scan and a flush state that hands over any final result. A second pointer
// writes surviving entries back so that removed tasks are compacted in the same pass.
// The request channel is not ready during that pass; results leave one per cycle
// through an output register, and a stalled result channel pauses the pass.
module multi_task_interval_timer
  import mtit_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mtit_cmd_if.sink   cmd,
  mtit_res_if.source res
);

  state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  r_idx;
  logic [CNT_W-1:0]  w_idx;
  logic [RES_W-1:0]  n_res;
  logic              found;
  command_t          cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [IVL_W-1:0]  ivl_q;
  logic [TIME_W-1:0] now_q;
  logic              pend_valid;
  res_t              pend;
  logic              out_valid;
  res_t              out_res;
  logic              out_last;

  tbl_wr_t           tbl_wr;
  entry_t            cur;
  entry_t            upd;

  logic              accept;
  logic              is_full;
  logic              out_free;
  logic              scan_done;
  logic              limit_hit;
  logic [TIME_W-1:0] elapsed;
  logic              match;
  logic              fires;
  logic              counted;
  logic [REM_W-1:0]  rem_dec;
  logic              fin;
  logic              drop;
  logic              scan_adv;
  logic              push_en;
  res_t              push_res;
  logic              push_last;

  mtit_table u_table (
    .clk     (clk),
    .wr      (tbl_wr),
    .rd_idx  (r_idx[IDX_W-1:0]),
    .rd_data (cur)
  );

  assign accept    = cmd.valid && cmd.ready;
  assign is_full   = (count == CNT_W'(MAX_TASKS));
  assign out_free  = !out_valid || res.ready;
  assign scan_done = (r_idx == count);
  assign limit_hit = (n_res == RES_W'(MAX_RESULTS));

  // Shared unit: wrapped elapsed time against the interval, and the count step.
  assign elapsed = now_q - cur.start;
  assign match   = (cur.id == id_q) && !found;
  assign fires   = (cmd_q == CMD_TICK) && !limit_hit &&
                   (elapsed >= TIME_W'(cur.interval));
  assign counted = (cur.remaining != '0);
  assign rem_dec = cur.remaining - REM_W'(1);
  assign fin     = fires && counted && (rem_dec == '0);
  assign drop    = fin || ((cmd_q == CMD_STOP) && match);

  // Updated copy of the entry under the read pointer.
  always_comb begin
    upd = cur;
    if (fires) begin
      upd.start = now_q;
      if (counted) begin
        upd.remaining = rem_dec;
      end
    end
    if ((cmd_q == CMD_SET) && match) begin
      upd.interval = ivl_q;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command_t'(cmd.command) == CMD_ADD) begin
            state_next = is_full ? ST_FLUSH : ST_IDLE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: table write, scan advance and result push.
  always_comb begin
    cmd.ready   = (state == ST_IDLE);
    tbl_wr      = '0;
    scan_adv    = 1'b0;
    push_en     = 1'b0;
    push_res    = pend;
    push_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && (command_t'(cmd.command) == CMD_ADD) && !is_full) begin
          tbl_wr.en             = 1'b1;
          tbl_wr.idx            = count[IDX_W-1:0];
          tbl_wr.data.id        = cmd.task_id;
          tbl_wr.data.interval  = cmd.interval_ms;
          tbl_wr.data.start     = cmd.now_ms;
          tbl_wr.data.remaining = cmd.run_limit;
        end
      end
      ST_SCAN: begin
        if (!scan_done) begin
          scan_adv = !(fires && pend_valid) || out_free;
          if (scan_adv) begin
            tbl_wr.en   = !drop;
            tbl_wr.idx  = w_idx[IDX_W-1:0];
            tbl_wr.data = upd;
            push_en     = fires && pend_valid;
          end
        end
      end
      ST_FLUSH: begin
        push_en   = pend_valid && out_free;
        push_last = 1'b1;
      end
      default: begin
        tbl_wr = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        out_valid <= push_en;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && (command_t'(cmd.command) == CMD_ADD)) begin
            if (is_full) begin
              pend_valid <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            count <= w_idx;
          end else if (scan_adv && fires) begin
            pend_valid <= 1'b1;
          end
        end
        ST_FLUSH: begin
          if (push_en) begin
            pend_valid <= 1'b0;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Scan pointers, latched request and result payloads.
  always_ff @(posedge clk) begin
    if (push_en) begin
      out_res  <= push_res;
      out_last <= push_last;
    end
    if (state == ST_IDLE) begin
      if (accept) begin
        cmd_q  <= command_t'(cmd.command);
        id_q   <= cmd.task_id;
        ivl_q  <= cmd.interval_ms;
        now_q  <= cmd.now_ms;
        r_idx  <= '0;
        w_idx  <= '0;
        n_res  <= '0;
        found  <= 1'b0;
        pend.kind <= KIND_REJECT;
        pend.id   <= cmd.task_id;
        pend.fin  <= 1'b0;
      end
    end else if (scan_adv) begin
      r_idx <= r_idx + CNT_W'(1);
      if (!drop) begin
        w_idx <= w_idx + CNT_W'(1);
      end
      if (match && ((cmd_q == CMD_SET) || (cmd_q == CMD_STOP))) begin
        found <= 1'b1;
      end
      if (fires) begin
        n_res     <= n_res + RES_W'(1);
        pend.kind <= KIND_FIRED;
        pend.id   <= cur.id;
        pend.fin  <= fin;
      end
    end
  end

  assign res.valid         = out_valid;
  assign res.result_kind   = out_res.kind;
  assign res.fired_task_id = out_res.id;
  assign res.finished      = out_res.fin;
  assign res.last          = out_last;

endmodule
